FILE: sv/assert_macros.svh
// Assertion macros shared by the digest RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an expression holds whenever the clock rises, outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Check that a condition implies a consequence on the same clock edge.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies a consequence on the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: sv/sha512_pkg.sv
// Package with types, round constants and initial values for the SHA-512 family.
`default_nettype none
package sha512_pkg;
    localparam int WORD_W = 64;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        KIND_SHA512     = 2'd0,
        KIND_SHA384     = 2'd1,
        KIND_SHA512_256 = 2'd2,
        KIND_SHA512_224 = 2'd3
    } kind_t;

    // Back-end job: absorb one word into the block, with its byte count and last flag.
    typedef struct packed {
        word_t      data;
        logic [3:0] count;
        logic       last;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_COMPRESS,
        ST_PAD,
        ST_EMIT
    } state_t;

    function automatic word_t round_const(input logic [6:0] r);
        word_t k;
        case (r)
            7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t init_value(input kind_t kind, input logic [2:0] i);
        word_t v;
        case ({kind, i})
            {KIND_SHA512, 3'd0}: v = 64'h6a09e667f3bcc908;
            {KIND_SHA512, 3'd1}: v = 64'hbb67ae8584caa73b;
            {KIND_SHA512, 3'd2}: v = 64'h3c6ef372fe94f82b;
            {KIND_SHA512, 3'd3}: v = 64'ha54ff53a5f1d36f1;
            {KIND_SHA512, 3'd4}: v = 64'h510e527fade682d1;
            {KIND_SHA512, 3'd5}: v = 64'h9b05688c2b3e6c1f;
            {KIND_SHA512, 3'd6}: v = 64'h1f83d9abfb41bd6b;
            {KIND_SHA512, 3'd7}: v = 64'h5be0cd19137e2179;
            {KIND_SHA384, 3'd0}: v = 64'hcbbb9d5dc1059ed8;
            {KIND_SHA384, 3'd1}: v = 64'h629a292a367cd507;
            {KIND_SHA384, 3'd2}: v = 64'h9159015a3070dd17;
            {KIND_SHA384, 3'd3}: v = 64'h152fecd8f70e5939;
            {KIND_SHA384, 3'd4}: v = 64'h67332667ffc00b31;
            {KIND_SHA384, 3'd5}: v = 64'h8eb44a8768581511;
            {KIND_SHA384, 3'd6}: v = 64'hdb0c2e0d64f98fa7;
            {KIND_SHA384, 3'd7}: v = 64'h47b5481dbefa4fa4;
            {KIND_SHA512_256, 3'd0}: v = 64'h22312194fc2bf72c;
            {KIND_SHA512_256, 3'd1}: v = 64'h9f555fa3c84c64c2;
            {KIND_SHA512_256, 3'd2}: v = 64'h2393b86b6f53b151;
            {KIND_SHA512_256, 3'd3}: v = 64'h963877195940eabd;
            {KIND_SHA512_256, 3'd4}: v = 64'h96283ee2a88effe3;
            {KIND_SHA512_256, 3'd5}: v = 64'hbe5e1e2553863992;
            {KIND_SHA512_256, 3'd6}: v = 64'h2b0199fc2c85b8aa;
            {KIND_SHA512_256, 3'd7}: v = 64'h0eb72ddc81c52ca2;
            {KIND_SHA512_224, 3'd0}: v = 64'h8c3d37c819544da2;
            {KIND_SHA512_224, 3'd1}: v = 64'h73e1996689dcd4d6;
            {KIND_SHA512_224, 3'd2}: v = 64'h1dfab7ae32ff9c82;
            {KIND_SHA512_224, 3'd3}: v = 64'h679dd514582f9fcf;
            {KIND_SHA512_224, 3'd4}: v = 64'h0f6d2b697bd44da8;
            {KIND_SHA512_224, 3'd5}: v = 64'h77e36f7304c48942;
            {KIND_SHA512_224, 3'd6}: v = 64'h3f9d85a86a1d36c8;
            {KIND_SHA512_224, 3'd7}: v = 64'h1112e6ad91d692a1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

FILE: sv/sha512_front.sv
// Front end: take command words, clamp the byte count, push jobs into a short queue.
`default_nettype none
module sha512_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  flush,
    input  wire                  start,
    output logic                 busy,
    input  wire [63:0]           msg_word,
    input  wire [3:0]            byte_count,
    input  wire                  last_item,
    output logic                 job_valid,
    output sha512_pkg::job_t     job,
    input  wire                  job_pop
);
    import sha512_pkg::*;

    localparam int DEPTH = 2;

    job_t       q_reg [DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    job_t       in_job;

    assign busy      = (cnt_reg == 2'(DEPTH));
    assign push      = start && !busy;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];

    always_comb
    begin
        in_job.data  = msg_word;
        in_job.count = (byte_count > 4'd8) ? 4'd8 : byte_count;
        in_job.last  = last_item;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else if (flush)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (job_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(job_pop);
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, job_pop, job_valid)
    `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_reg <= 2'(DEPTH))
    `ASSERT_NEXT(a_push_visible, clk, rst_n, push && !job_pop && !flush, job_valid)
endmodule
`default_nettype wire

FILE: sv/sha512_core.sv
// Back end: block buffer, byte counter, round engine, padding and digest output.
`default_nettype none
module sha512_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  reinit,
    input  wire [1:0]            kind,
    input  wire                  job_valid,
    input  wire sha512_pkg::job_t job,
    output logic                 job_pop,
    output logic                 idle,
    output logic                 out_strobe,
    output logic [63:0]          digest_word,
    output logic [3:0]           valid_bytes,
    output logic                 last_word
);
    import sha512_pkg::*;

    state_t     state_reg, state_next;
    word_t      blk_reg [16];
    word_t      h_reg [8];
    word_t      v_reg [8];
    logic [63:0] total_reg;
    logic [6:0]  rnd_reg;
    logic [3:0]  bi_reg;     // byte index within current job
    logic [2:0]  oi_reg;     // output word index
    logic        pad2_reg;   // second compression still owed for the length block
    logic        fin_reg;    // compression belongs to finalization
    job_t        job_reg;

    kind_t      kd;
    logic [6:0] off;
    logic [3:0] idx;
    logic [5:0] sh;
    logic [2:0] nout;
    word_t      w, t1, t2, s0, s1, w15, w2, e, a;

    assign kd  = kind_t'(kind);
    assign off = total_reg[6:0];
    assign idx = off[6:3];
    assign sh  = 6'd56 - {off[2:0], 3'b000};

    always_comb
    begin
        case (kd)
            KIND_SHA512: nout = 3'd7;
            KIND_SHA384: nout = 3'd5;
            default:     nout = 3'd3;
        endcase
    end

    // Message schedule and round arithmetic.
    always_comb
    begin
        w15 = blk_reg[1];
        w2  = blk_reg[14];
        s0  = {w15[0], w15[63:1]} ^ {w15[7:0], w15[63:8]} ^ (w15 >> 7);
        s1  = {w2[18:0], w2[63:19]} ^ {w2[60:0], w2[63:61]} ^ (w2 >> 6);
        w   = (rnd_reg < 7'd16) ? blk_reg[0] : (s1 + blk_reg[9] + s0 + blk_reg[0]);
        e   = v_reg[4];
        a   = v_reg[0];
        t1  = v_reg[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
            + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_const(rnd_reg) + w;
        t2  = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
            + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (job_valid)
                begin
                    state_next = ST_ABSORB;
                end
            ST_ABSORB:
                if (bi_reg < job_reg.count && off == 7'd127)
                begin
                    state_next = ST_COMPRESS;
                end
                else if (bi_reg >= job_reg.count)
                begin
                    state_next = job_reg.last ? ST_PAD : ST_IDLE;
                end
            ST_PAD:
                state_next = ST_COMPRESS;
            ST_COMPRESS:
                if (rnd_reg == 7'd80)
                begin
                    if (pad2_reg)
                    begin
                        state_next = ST_COMPRESS;
                    end
                    else if (fin_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_ABSORB;
                    end
                end
            ST_EMIT:
                if (oi_reg == nout)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop     = (state_reg == ST_IDLE) && job_valid;
        idle        = (state_reg == ST_IDLE) && !job_valid;
        out_strobe  = (state_reg == ST_EMIT);
        digest_word = h_reg[oi_reg];
        valid_bytes = 4'd8;
        last_word   = (oi_reg == nout);
        if (kd == KIND_SHA512_224 && oi_reg == 3'd3)
        begin
            digest_word = {h_reg[3][63:32], 32'd0};
            valid_bytes = 4'd4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            rnd_reg   <= '0;
            bi_reg    <= '0;
            oi_reg    <= '0;
            pad2_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            job_reg   <= '0;
            for (int i = 0; i < 16; i++)
            begin
                blk_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_value(KIND_SHA512, 3'(i));
                v_reg[i] <= '0;
            end
        end
        else if (reinit || (state_reg == ST_EMIT && oi_reg == nout))
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            rnd_reg   <= '0;
            bi_reg    <= '0;
            oi_reg    <= '0;
            pad2_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                blk_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_value(kd, 3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                    if (job_valid)
                    begin
                        job_reg <= job;
                        bi_reg  <= '0;
                    end
                ST_ABSORB:
                    if (bi_reg < job_reg.count)
                    begin
                        blk_reg[idx] <= (blk_reg[idx] & ~(64'hff << sh))
                            | (64'(job_reg.data[63 - {bi_reg[2:0], 3'b000} -: 8]) << sh);
                        total_reg <= total_reg + 64'd1;
                        bi_reg    <= bi_reg + 4'd1;
                        if (off == 7'd127)
                        begin
                            rnd_reg <= '0;
                            fin_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                v_reg[i] <= h_reg[i];
                            end
                        end
                    end
                ST_PAD:
                begin
                    // Tail already zero: set the marker byte, place length if it fits.
                    blk_reg[idx] <= blk_reg[idx] | (64'h80 << sh);
                    pad2_reg <= (off >= 7'd112);
                    fin_reg  <= 1'b1;
                    rnd_reg  <= '0;
                    oi_reg   <= '0;
                    if (off < 7'd112)
                    begin
                        blk_reg[14] <= {61'd0, total_reg[63:61]};
                        blk_reg[15] <= {total_reg[60:0], 3'b000};
                    end
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                end
                ST_COMPRESS:
                    if (rnd_reg == 7'd80)
                    begin
                        rnd_reg <= '0;
                        for (int i = 0; i < 16; i++)
                        begin
                            blk_reg[i] <= '0;
                        end
                        for (int i = 0; i < 8; i++)
                        begin
                            h_reg[i] <= h_reg[i] + v_reg[i];
                            v_reg[i] <= h_reg[i] + v_reg[i];
                        end
                        if (pad2_reg)
                        begin
                            pad2_reg    <= 1'b0;
                            blk_reg[14] <= {61'd0, total_reg[63:61]};
                            blk_reg[15] <= {total_reg[60:0], 3'b000};
                        end
                    end
                    else
                    begin
                        // Rotate the 16-word window; slot 15 takes this round's word.
                        for (int i = 0; i < 15; i++)
                        begin
                            blk_reg[i] <= blk_reg[i + 1];
                        end
                        blk_reg[15] <= w;
                        v_reg[0] <= t1 + t2;
                        v_reg[1] <= v_reg[0];
                        v_reg[2] <= v_reg[1];
                        v_reg[3] <= v_reg[2];
                        v_reg[4] <= v_reg[3] + t1;
                        v_reg[5] <= v_reg[4];
                        v_reg[6] <= v_reg[5];
                        v_reg[7] <= v_reg[6];
                        rnd_reg  <= rnd_reg + 7'd1;
                    end
                ST_EMIT:
                    oi_reg <= oi_reg + 3'd1;
                default:
                    ;
            endcase
        end
    end

    `include "assert_macros.svh"
    `ASSERT_ALWAYS(a_round_range, clk, rst_n, rnd_reg <= 7'd80)
    `ASSERT_IMPLIES(a_strobe_emit, clk, rst_n, out_strobe, state_reg == ST_EMIT)
    `ASSERT_IMPLIES(a_pop_idle, clk, rst_n, job_pop, state_reg == ST_IDLE)
endmodule
`default_nettype wire

FILE: sv/sha512_message_digest.sv
// Top level of the SHA-512 family digest: front queue, compression core, config register.
// Each word is absorbed byte by byte; a full block then runs through the compression rounds.
// The front queue takes new words while the core works on earlier ones, until it is full.
// The last word adds padding, one or two compressions and 4 to 8 output words.
// Results come one per cycle on strobe; the receiver cannot stall them.
// Reset (async, rst_n low) selects SHA-512 and clears the message state.
`default_nettype none
module sha512_message_digest (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire [63:0]  msg_word,
    input  wire [3:0]   byte_count,
    input  wire         last_item,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [1:0]   cfg_data,
    output logic        strobe,
    output logic [63:0] digest_word,
    output logic [3:0]  valid_bytes,
    output logic        last_word
);
    import sha512_pkg::*;

    logic [1:0] kind_reg;
    logic       cfg_wr;
    logic       job_valid, job_pop, core_idle;
    job_t       job;

    // Take a kind write at any time; it abandons the message in flight.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= 2'd0;
        end
        else if (cfg_wr)
        begin
            kind_reg <= cfg_data;
        end
    end

    sha512_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .flush      (cfg_wr),
        .start      (start),
        .busy       (busy),
        .msg_word   (msg_word),
        .byte_count (byte_count),
        .last_item  (last_item),
        .job_valid  (job_valid),
        .job        (job),
        .job_pop    (job_pop)
    );

    // Reinit uses the new kind, so feed the write data through on the write cycle.
    sha512_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .reinit      (cfg_wr),
        .kind        (cfg_wr ? cfg_data : kind_reg),
        .job_valid   (job_valid),
        .job         (job),
        .job_pop     (job_pop),
        .idle        (core_idle),
        .out_strobe  (strobe),
        .digest_word (digest_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word)
    );

    `include "assert_macros.svh"
    `ASSERT_IMPLIES(a_idle_no_strobe, clk, rst_n, core_idle, !strobe)
    `ASSERT_IMPLIES(a_last_strobe, clk, rst_n, last_word && strobe, valid_bytes >= 4'd4)
    `ASSERT_NEXT(a_cfg_no_strobe, clk, rst_n, cfg_wr, !strobe)
endmodule
`default_nettype wire
